/* rtl/bclrt_pkg.sv */
// Shared types and constants for the bytecode line run table.
// Used by bclrt_search and bytecode_line_run_table; no dependencies.
package bclrt_pkg;

  // Default store sizes
  localparam int CodeDepthDef = 4096;
  localparam int RunDepthDef  = 1024;
  localparam int LineBitsDef  = 16;

  // Fixed port field widths
  localparam int OpW     = 2;
  localparam int ByteW   = 8;
  localparam int LineW   = 16;
  localparam int OffW    = 12;
  localparam int StatusW = 2;
  localparam int StoredW = 13;

  // Op codes
  localparam logic [OpW-1:0] OP_APPEND = 2'd0;
  localparam logic [OpW-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OpW-1:0] OP_CLEAR  = 2'd2;

  // Status codes
  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic start;
  } srch_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } srch_rsp_t;

endpackage

/* rtl/bclrt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bclrt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* rtl/bclrt_search.sv */
// Binary search sequencer over the run start store (address, then compare).
// Depends on bclrt_pkg; the run RAM itself sits in the top level.
module bclrt_search #(
  parameter int IdxW   = 10,
  parameter int StartW = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bclrt_pkg::srch_req_t        req_i,
  input  logic [IdxW-1:0]             last_i,
  input  logic [bclrt_pkg::OffW-1:0]  off_i,
  input  logic [StartW-1:0]           start_i,
  output logic                        rd_en_o,
  output logic [IdxW-1:0]             rd_addr_o,
  output logic [IdxW-1:0]             idx_o,
  output bclrt_pkg::srch_rsp_t        rsp_o
);

  localparam int CmpW = (StartW > bclrt_pkg::OffW) ? StartW : bclrt_pkg::OffW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ADDR = 4'b0010,
    S_CMP  = 4'b0100,
    S_DONE = 4'b1000
  } srch_state_e;

  srch_state_e     state_q, state_d;
  logic [IdxW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [IdxW-1:0] lo_n, hi_n;
  logic [IdxW:0]   mid_sum;
  logic            le_off;

  // upper midpoint, so lo always moves on a hit
  assign mid_sum = (IdxW+1)'(lo_q) + (IdxW+1)'(hi_q) + (IdxW+1)'(1);
  assign le_off  = CmpW'(start_i) <= CmpW'(off_i);

  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    lo_n    = lo_q;
    hi_n    = hi_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          lo_d    = '0;
          hi_d    = last_i;
          state_d = (last_i == '0) ? S_DONE : S_ADDR;
        end
      end
      S_ADDR: begin
        mid_d   = mid_sum[IdxW:1];
        state_d = S_CMP;
      end
      S_CMP: begin
        if (le_off) begin
          lo_n = mid_q;
        end else begin
          hi_n = mid_q - IdxW'(1);
        end
        lo_d    = lo_n;
        hi_d    = hi_n;
        state_d = (lo_n < hi_n) ? S_ADDR : S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
  end

  assign rd_en_o    = (state_q == S_ADDR);
  assign rd_addr_o  = mid_sum[IdxW:1];
  assign idx_o      = lo_q;
  assign rsp_o.busy = (state_q != S_IDLE);
  assign rsp_o.done = (state_q == S_DONE);

endmodule

/* rtl/bytecode_line_run_table.sv */
// Bytecode line run table: code byte store plus run-length offset-to-line map.
// Append, clear, unused ops and lookup on an empty table: accept, then the emit state
// loads the output register. Other lookups: accept, then a binary search over the run RAM
// (each probe gives an address, then compares the registered read data), a read of the
// winning run's line, then emit. A full output register adds its stall. One item at a
// time; a result waits in the output register while the next beat is taken. Reset clears
// counts and control only; RAM contents are not cleared.
module bytecode_line_run_table #(
  parameter int CodeDepth = bclrt_pkg::CodeDepthDef,
  parameter int RunDepth  = bclrt_pkg::RunDepthDef,
  parameter int LineBits  = bclrt_pkg::LineBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bclrt_pkg::OpW-1:0]      op_i,
  input  logic [bclrt_pkg::ByteW-1:0]    byte_value_i,
  input  logic [bclrt_pkg::LineW-1:0]    line_number_i,
  input  logic [bclrt_pkg::OffW-1:0]     byte_offset_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bclrt_pkg::StatusW-1:0]  status_o,
  output logic [bclrt_pkg::LineW-1:0]    found_line_o,
  output logic [bclrt_pkg::ByteW-1:0]    found_byte_o,
  output logic [bclrt_pkg::StoredW-1:0]  stored_count_o
);

  localparam int Aw    = $clog2(CodeDepth);
  localparam int CntW  = Aw + 1;
  localparam int Rw    = $clog2(RunDepth);
  localparam int RcntW = Rw + 1;
  localparam int RunW  = Aw + LineBits;
  localparam int WideL = (LineBits > bclrt_pkg::LineW) ? LineBits : bclrt_pkg::LineW;
  localparam int WideC = (CntW > bclrt_pkg::StoredW) ? CntW : bclrt_pkg::StoredW;
  localparam int CmpW  = (CntW > bclrt_pkg::OffW) ? CntW : bclrt_pkg::OffW;

  typedef enum logic [4:0] {
    T_IDLE   = 5'b00001,
    T_SEARCH = 5'b00010,
    T_LINE   = 5'b00100,
    T_EMIT   = 5'b01000,
    T_SPARE  = 5'b10000
  } top_state_e;

  top_state_e state_q, state_d;

  logic [CntW-1:0]     byte_count_q, byte_count_d;
  logic [RcntW-1:0]    run_count_q, run_count_d;
  logic [LineBits-1:0] last_line_q, last_line_d;
  logic [bclrt_pkg::OffW-1:0]    off_q;
  logic                          in_range_q;
  logic [bclrt_pkg::StatusW-1:0] res_status_q, res_status_d;
  logic [bclrt_pkg::LineW-1:0]   res_line_q, res_line_d;
  logic                          res_byte_en_q, res_byte_en_d;

  logic                          out_valid_q;
  logic [bclrt_pkg::StatusW-1:0] out_status_q;
  logic [bclrt_pkg::LineW-1:0]   out_line_q;
  logic [bclrt_pkg::ByteW-1:0]   out_byte_q;
  logic [bclrt_pkg::StoredW-1:0] out_count_q;

  logic                 accept, slot_free, new_run, code_full, run_full;
  logic [WideL-1:0]     line_wide, rline_wide;
  logic [LineBits-1:0]  line_in;
  logic [WideC-1:0]     count_wide;

  logic                 code_we, run_we, run_re;
  logic [Rw-1:0]        run_raddr;
  logic [RunW-1:0]      run_rdata;
  logic [bclrt_pkg::ByteW-1:0] code_rdata;

  bclrt_pkg::srch_req_t srch_req;
  bclrt_pkg::srch_rsp_t srch_rsp;
  logic                 srch_rd_en;
  logic [Rw-1:0]        srch_rd_addr, srch_idx, srch_last;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == T_IDLE);
  assign slot_free  = !out_valid_q || out_ready_i;

  // keep only the low LineBits of the incoming line
  assign line_wide = WideL'(line_number_i);
  assign line_in   = line_wide[LineBits-1:0];

  assign new_run   = (run_count_q == '0) || (last_line_q != line_in);
  assign code_full = byte_count_q >= CntW'(CodeDepth);
  assign run_full  = new_run && (run_count_q >= RcntW'(RunDepth));

  assign code_we = accept && (op_i == bclrt_pkg::OP_APPEND) && !code_full && !run_full;
  assign run_we  = code_we && new_run;

  assign srch_req.start = accept && (op_i == bclrt_pkg::OP_LOOKUP) && (run_count_q != '0);
  assign srch_last      = Rw'(run_count_q - RcntW'(1));

  // final read of the winning run shares the port with the search probes
  assign run_re    = srch_rd_en || ((state_q == T_SEARCH) && srch_rsp.done);
  assign run_raddr = srch_rd_en ? srch_rd_addr : srch_idx;

  bclrt_ram #(
    .Width(bclrt_pkg::ByteW),
    .Depth(CodeDepth)
  ) u_code_ram (
    .clk_i  (clk_i),
    .we_i   (code_we),
    .waddr_i(byte_count_q[Aw-1:0]),
    .wdata_i(byte_value_i),
    .re_i   (accept && (op_i == bclrt_pkg::OP_LOOKUP)),
    .raddr_i(Aw'(byte_offset_i)),
    .rdata_o(code_rdata)
  );

  bclrt_ram #(
    .Width(RunW),
    .Depth(RunDepth)
  ) u_run_ram (
    .clk_i  (clk_i),
    .we_i   (run_we),
    .waddr_i(run_count_q[Rw-1:0]),
    .wdata_i({byte_count_q[Aw-1:0], line_in}),
    .re_i   (run_re),
    .raddr_i(run_raddr),
    .rdata_o(run_rdata)
  );

  bclrt_search #(
    .IdxW  (Rw),
    .StartW(Aw)
  ) u_search (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (srch_req),
    .last_i   (srch_last),
    .off_i    (off_q),
    .start_i  (run_rdata[RunW-1:LineBits]),
    .rd_en_o  (srch_rd_en),
    .rd_addr_o(srch_rd_addr),
    .idx_o    (srch_idx),
    .rsp_o    (srch_rsp)
  );

  assign rline_wide = WideL'(run_rdata[LineBits-1:0]);

  always_comb begin
    state_d       = state_q;
    byte_count_d  = byte_count_q;
    run_count_d   = run_count_q;
    last_line_d   = last_line_q;
    res_status_d  = res_status_q;
    res_line_d    = res_line_q;
    res_byte_en_d = res_byte_en_q;
    case (state_q)
      T_IDLE: begin
        if (accept) begin
          res_status_d  = bclrt_pkg::ST_OK;
          res_line_d    = '0;
          res_byte_en_d = 1'b0;
          state_d       = T_EMIT;
          case (op_i)
            bclrt_pkg::OP_APPEND: begin
              if (code_full || run_full) begin
                res_status_d = bclrt_pkg::ST_FULL;
              end else begin
                byte_count_d = byte_count_q + CntW'(1);
                if (new_run) begin
                  run_count_d = run_count_q + RcntW'(1);
                  last_line_d = line_in;
                end
              end
            end
            bclrt_pkg::OP_LOOKUP: begin
              if (run_count_q == '0) begin
                res_status_d = bclrt_pkg::ST_EMPTY;
              end else begin
                state_d = T_SEARCH;
              end
            end
            bclrt_pkg::OP_CLEAR: begin
              byte_count_d = '0;
              run_count_d  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      T_SEARCH: begin
        if (srch_rsp.done) begin
          state_d = T_LINE;
        end
      end
      T_LINE: begin
        res_line_d    = rline_wide[bclrt_pkg::LineW-1:0];
        res_byte_en_d = in_range_q;
        state_d       = T_EMIT;
      end
      T_EMIT: begin
        if (slot_free) begin
          state_d = T_IDLE;
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= T_IDLE;
      byte_count_q <= '0;
      run_count_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      byte_count_q <= byte_count_d;
      run_count_q  <= run_count_d;
      if ((state_q == T_EMIT) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign count_wide = WideC'(byte_count_q);

  always_ff @(posedge clk_i) begin
    last_line_q   <= last_line_d;
    res_status_q  <= res_status_d;
    res_line_q    <= res_line_d;
    res_byte_en_q <= res_byte_en_d;
    if (accept) begin
      off_q      <= byte_offset_i;
      in_range_q <= CmpW'(byte_offset_i) < CmpW'(byte_count_q);
    end
    if ((state_q == T_EMIT) && slot_free) begin
      out_status_q <= res_status_q;
      out_line_q   <= res_line_q;
      out_byte_q   <= res_byte_en_q ? code_rdata : '0;
      out_count_q  <= count_wide[bclrt_pkg::StoredW-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign found_line_o   = out_line_q;
  assign found_byte_o   = out_byte_q;
  assign stored_count_o = out_count_q;

  // every run starts at a stored byte
  a_runs_le_bytes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (RcntW + CntW)'(run_count_q) <= (RcntW + CntW)'(byte_count_q))
    else $error("run count exceeds byte count");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_count_q <= CntW'(CodeDepth))
    else $error("byte count beyond code store depth");

  a_search_owned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    srch_rsp.busy |-> (state_q == T_SEARCH))
    else $error("search running outside lookup");

  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == bclrt_pkg::ST_EMPTY)) |->
      (found_line_o == '0) && (found_byte_o == '0))
    else $error("empty-table result carries data");

endmodule
